@@ sv/dccpd_pkg.sv @@
// Shared types, codes and reset constants for the DCC track packet decoder.
`timescale 1ns / 1ps
`default_nettype none

package dccpd_pkg;

    // Default number of packet byte slots held while a packet is gathered.
    localparam int PACKET_SLOTS_DEF = 6;
    // Packet bytes presented on the result word.
    localparam int SHOWN_BYTES = 5;

    localparam int TIME_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int LEN_W     = 3;

    // Register values after reset.
    localparam logic [TIME_W-1:0] ONE_HALF_MIN_RST  = 16'd52;
    localparam logic [TIME_W-1:0] ONE_HALF_MAX_RST  = 16'd64;
    localparam logic [TIME_W-1:0] ZERO_HALF_MIN_RST = 16'd90;
    localparam logic [TIME_W-1:0] ZERO_HALF_MAX_RST = 16'd10000;
    localparam logic [7:0]        PREAMBLE_MIN_RST  = 8'd10;

    localparam logic [7:0] ONES_SAT  = 8'hFF;
    localparam logic [7:0] BIT_MASK  = 8'h01;
    localparam logic [2:0] MSB_POS   = 3'd7;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_MODE     = 3'd0,
        REG_ONE_HALF_MIN  = 3'd1,
        REG_ONE_HALF_MAX  = 3'd2,
        REG_ZERO_HALF_MIN = 3'd3,
        REG_ZERO_HALF_MAX = 3'd4,
        REG_PREAMBLE_MIN  = 3'd5
    } cfg_reg_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_TIMING_ERR = 2'd1,
        ST_PKT_GOOD   = 2'd2,
        ST_PKT_BAD    = 2'd3
    } status_t;

    // Framer phases.
    typedef enum logic [1:0] {
        PH_PREAMBLE = 2'd0,
        PH_DATA     = 2'd1,
        PH_SEP      = 2'd2
    } phase_t;

    // Classified track bit.
    typedef enum logic [1:0] {
        BIT_ZERO = 2'd0,
        BIT_ONE  = 2'd1,
        BIT_BAD  = 2'd2
    } bit_kind_t;

    // Configuration register file contents.
    typedef struct packed {
        logic              edge_mode;
        logic [TIME_W-1:0] one_half_min;
        logic [TIME_W-1:0] one_half_max;
        logic [TIME_W-1:0] zero_half_min;
        logic [TIME_W-1:0] zero_half_max;
        logic [7:0]        preamble_min_ones;
    } cfg_t;

    // Bit event handed from the classifier to the framer.
    typedef struct packed {
        logic      feed;        // a bit (possibly bad) goes to the framer
        bit_kind_t kind;
        logic      timing_err;  // bad whole bit, reported without state change
    } bit_evt_t;

endpackage

`default_nettype wire

@@ sv/dccpd_bit_class.sv @@
// Interval classifier: turns one edge interval into a framer bit event.
`timescale 1ns / 1ps
`default_nettype none

module dccpd_bit_class
    import dccpd_pkg::*;
(
    input  wire cfg_t              cfg,
    input  wire logic [TIME_W-1:0] interval,
    input  wire logic [TIME_W-1:0] held_half,
    output bit_evt_t               evt,
    output logic [TIME_W-1:0]      held_next
);

    bit_kind_t first_kind;
    bit_kind_t second_kind;
    bit_kind_t whole_kind;
    bit_kind_t pair_kind;

    // Half-bit classification; a one wins where the ranges overlap.
    function automatic bit_kind_t half_kind(input cfg_t c, input logic [TIME_W-1:0] t);
        bit_kind_t k;
        if (t >= c.one_half_min && t <= c.one_half_max) begin
            k = BIT_ONE;
        end else if (t >= c.zero_half_min && t <= c.zero_half_max) begin
            k = BIT_ZERO;
        end else begin
            k = BIT_BAD;
        end
        return k;
    endfunction

    assign first_kind  = half_kind(cfg, held_half);
    assign second_kind = half_kind(cfg, interval);

    // Whole-bit classification against doubled limits, no upper limit for a zero.
    always_comb begin
        if ({1'b0, interval} >= {cfg.one_half_min, 1'b0} &&
            {1'b0, interval} <= {cfg.one_half_max, 1'b0}) begin
            whole_kind = BIT_ONE;
        end else if ({1'b0, interval} >= {cfg.zero_half_min, 1'b0}) begin
            whole_kind = BIT_ZERO;
        end else begin
            whole_kind = BIT_BAD;
        end
    end

    // Pairing of two half bits.
    always_comb begin
        if (first_kind == BIT_ONE && second_kind == BIT_ONE) begin
            pair_kind = BIT_ONE;
        end else if (first_kind == BIT_ZERO && second_kind == BIT_ZERO) begin
            pair_kind = BIT_ZERO;
        end else begin
            pair_kind = BIT_BAD;
        end
    end

    // Event and the half bit kept for the next word.
    always_comb begin
        evt.feed       = 1'b0;
        evt.kind       = BIT_BAD;
        evt.timing_err = 1'b0;
        held_next      = held_half;
        if (!cfg.edge_mode) begin
            if (held_half == '0) begin
                held_next = interval;
            end else begin
                evt.feed  = 1'b1;
                evt.kind  = pair_kind;
                held_next = (pair_kind == BIT_BAD) ? interval : '0;
            end
        end else begin
            if (whole_kind == BIT_BAD) begin
                evt.timing_err = 1'b1;
            end else begin
                evt.feed = 1'b1;
                evt.kind = whole_kind;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/dcc_track_packet_decoder_core.sv @@
// Top level of the DCC track packet decoder: input register, framer and result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Contents
// s_        in         s_valid / s_ready    one edge interval word
// m_        out        m_valid / m_ready    status, packet length and five packet bytes
// cfg_      in         cfg_we               register index and write data
//
// Every interval word gives exactly one result word; one per cycle while m_ready is high.
// A word is held in the input register and then appears in the result register.
// The framer state is updated in the cycle a word moves from input to result.
// While the result register is full and not taken, the input register holds and s_ready
// drops once it is full too. Reset is synchronous; no clearing pass is needed.

module dcc_track_packet_decoder_core
    import dccpd_pkg::*;
#(
    parameter int PACKET_SLOTS = PACKET_SLOTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [TIME_W-1:0]    s_interval,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_status,
    output logic [LEN_W-1:0]          m_packet_length,
    output logic [7:0]                m_packet_byte_a,
    output logic [7:0]                m_packet_byte_b,
    output logic [7:0]                m_packet_byte_c,
    output logic [7:0]                m_packet_byte_d,
    output logic [7:0]                m_packet_byte_e,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

    localparam int BC_W  = $clog2(PACKET_SLOTS + 1);
    localparam int IDX_W = $clog2(PACKET_SLOTS);

    cfg_t              cfg_reg;

    logic              in_valid_reg;
    logic [TIME_W-1:0] interval_reg;
    logic              advance;

    phase_t            phase_reg, phase_next;
    logic [7:0]        ones_reg, ones_next;
    logic [TIME_W-1:0] held_reg, held_next;
    logic [TIME_W-1:0] held_calc;
    logic [7:0]        shift_reg, shift_next;
    logic [2:0]        bitpos_reg, bitpos_next;
    logic [BC_W-1:0]   bc_reg, bc_next;
    logic [BC_W-1:0]   bc_inc;
    logic [7:0]        shifted;
    logic              store_we;
    logic [7:0]        packet_store [PACKET_SLOTS];
    logic [7:0]        xor_all;
    logic [7:0]        shown [SHOWN_BYTES];
    bit_evt_t          evt;

    status_t           res_status;
    logic [LEN_W-1:0]  res_length;
    logic              res_show;

    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [LEN_W-1:0]  m_length_reg;
    logic [7:0]        m_bytes_reg [SHOWN_BYTES];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edge_mode         <= 1'b0;
            cfg_reg.one_half_min      <= ONE_HALF_MIN_RST;
            cfg_reg.one_half_max      <= ONE_HALF_MAX_RST;
            cfg_reg.zero_half_min     <= ZERO_HALF_MIN_RST;
            cfg_reg.zero_half_max     <= ZERO_HALF_MAX_RST;
            cfg_reg.preamble_min_ones <= PREAMBLE_MIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_EDGE_MODE:     cfg_reg.edge_mode         <= cfg_wdata[0];
                REG_ONE_HALF_MIN:  cfg_reg.one_half_min      <= cfg_wdata;
                REG_ONE_HALF_MAX:  cfg_reg.one_half_max      <= cfg_wdata;
                REG_ZERO_HALF_MIN: cfg_reg.zero_half_min     <= cfg_wdata;
                REG_ZERO_HALF_MAX: cfg_reg.zero_half_max     <= cfg_wdata;
                REG_PREAMBLE_MIN:  cfg_reg.preamble_min_ones <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: a word moves on when the result register is free or being emptied.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            interval_reg <= s_interval;
        end
    end

    dccpd_bit_class u_bit_class (
        .cfg       (cfg_reg),
        .interval  (interval_reg),
        .held_half (held_reg),
        .evt       (evt),
        .held_next (held_calc)
    );

    assign bc_inc  = bc_reg + BC_W'(1);
    assign shifted = (evt.kind == BIT_ONE) ? (shift_reg | (BIT_MASK << bitpos_reg)) : shift_reg;

    // Checksum: the packet is good when all its bytes XOR to zero.
    always_comb begin
        xor_all = '0;
        for (int i = 0; i < PACKET_SLOTS; i++) begin
            if (BC_W'(i) < bc_reg) begin
                xor_all = xor_all ^ packet_store[i];
            end
        end
    end

    // Bytes shown on the result word; zero past the packet length.
    for (genvar g = 0; g < SHOWN_BYTES; g++) begin : g_shown
        if (g < PACKET_SLOTS) begin : g_slot
            assign shown[g] = (BC_W'(g) < bc_reg) ? packet_store[g] : 8'h00;
        end else begin : g_none
            assign shown[g] = 8'h00;
        end
    end

    // Framer phase: next state.
    always_comb begin
        phase_next = phase_reg;
        if (advance) begin
            if (interval_reg == '0) begin
                phase_next = PH_PREAMBLE;
            end else if (evt.feed && evt.kind != BIT_BAD) begin
                unique case (phase_reg)
                    PH_PREAMBLE: begin
                        if (evt.kind == BIT_ZERO && ones_reg >= cfg_reg.preamble_min_ones) begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (bitpos_reg == '0) begin
                            phase_next = (bc_inc >= BC_W'(PACKET_SLOTS)) ? PH_PREAMBLE : PH_SEP;
                        end
                    end
                    PH_SEP: begin
                        phase_next = (evt.kind == BIT_ZERO) ? PH_DATA : PH_PREAMBLE;
                    end
                    default: phase_next = PH_PREAMBLE;
                endcase
            end
        end
    end

    // Framer data path and result word.
    always_comb begin
        ones_next   = ones_reg;
        held_next   = held_reg;
        shift_next  = shift_reg;
        bitpos_next = bitpos_reg;
        bc_next     = bc_reg;
        store_we    = 1'b0;
        res_status  = ST_NONE;
        res_length  = '0;
        res_show    = 1'b0;
        if (advance) begin
            if (interval_reg == '0) begin
                ones_next = '0;
            end else begin
                held_next = held_calc;
                if (evt.timing_err) begin
                    res_status = ST_TIMING_ERR;
                end else if (evt.feed) begin
                    if (evt.kind == BIT_BAD) begin
                        res_status = ST_TIMING_ERR;
                        if (phase_reg == PH_PREAMBLE) begin
                            ones_next = '0;
                        end
                    end else begin
                        unique case (phase_reg)
                            PH_PREAMBLE: begin
                                if (evt.kind == BIT_ONE) begin
                                    if (ones_reg != ONES_SAT) begin
                                        ones_next = ones_reg + 8'd1;
                                    end
                                end else if (ones_reg >= cfg_reg.preamble_min_ones) begin
                                    shift_next  = '0;
                                    bitpos_next = MSB_POS;
                                    bc_next     = '0;
                                end else begin
                                    ones_next = '0;
                                end
                            end
                            PH_DATA: begin
                                if (bitpos_reg == '0) begin
                                    store_we    = 1'b1;
                                    shift_next  = '0;
                                    bitpos_next = MSB_POS;
                                    bc_next     = bc_inc;
                                    if (bc_inc >= BC_W'(PACKET_SLOTS)) begin
                                        ones_next = '0;
                                        bc_next   = '0;
                                    end
                                end else begin
                                    bitpos_next = bitpos_reg - 3'd1;
                                    shift_next  = shifted;
                                end
                            end
                            PH_SEP: begin
                                if (evt.kind == BIT_ONE) begin
                                    ones_next = '0;
                                    if (bc_reg != '0) begin
                                        res_status = (xor_all == 8'h00) ? ST_PKT_GOOD : ST_PKT_BAD;
                                        res_length = LEN_W'(bc_reg);
                                        res_show   = 1'b1;
                                    end
                                end
                            end
                            default: ones_next = '0;
                        endcase
                    end
                end
            end
        end
    end

    // Framer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PREAMBLE;
            ones_reg   <= '0;
            held_reg   <= '0;
            shift_reg  <= '0;
            bitpos_reg <= MSB_POS;
            bc_reg     <= '0;
        end else begin
            phase_reg  <= phase_next;
            ones_reg   <= ones_next;
            held_reg   <= held_next;
            shift_reg  <= shift_next;
            bitpos_reg <= bitpos_next;
            bc_reg     <= bc_next;
        end
    end

    // Packet byte store; entries are only read once written in the current packet.
    always_ff @(posedge aclk) begin
        if (store_we) begin
            packet_store[bc_reg[IDX_W-1:0]] <= shifted;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_status_reg <= res_status;
            m_length_reg <= res_length;
            for (int i = 0; i < SHOWN_BYTES; i++) begin
                m_bytes_reg[i] <= res_show ? shown[i] : 8'h00;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_packet_length = m_length_reg;
    assign m_packet_byte_a = m_bytes_reg[0];
    assign m_packet_byte_b = m_bytes_reg[1];
    assign m_packet_byte_c = m_bytes_reg[2];
    assign m_packet_byte_d = m_bytes_reg[3];
    assign m_packet_byte_e = m_bytes_reg[4];

endmodule

`default_nettype wire
